/* rtl/qrs_pkg.sv */
package qrs_pkg;

  localparam int unsigned CoefW = 64;
  localparam int unsigned EpsW  = 32;
  localparam logic [EpsW-1:0] EpsReset = 32'd42950;

  // square root chain: 192-bit radicand, one root bit per cell
  localparam int unsigned RadW      = 192;
  localparam int unsigned RootW     = RadW / 2;
  localparam int unsigned RemW      = RootW + 2;
  localparam int unsigned SqrtCells = RootW;

  // divider chain: 99-bit numerator, 65-bit divisor, one quotient bit per cell
  localparam int unsigned NumW     = 99;
  localparam int unsigned DenW     = 65;
  localparam int unsigned QuoW     = 64;
  localparam int unsigned DivCells = QuoW;
  localparam int unsigned Lanes    = 2;

  typedef enum logic [3:0] {
    K_NONE,   // no real root
    K_ZERO1,  // single root at zero
    K_LIN,    // linear solve
    K_BTEST,  // b near zero, epsilon test pending
    K_BSQ,    // plus/minus square root
    K_CZ,     // c near zero: 0 and -b/a
    K_DISC,   // discriminant sign pending
    K_DZ,     // double root
    K_DP      // two distinct roots
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              sa;
    logic              sb;
    logic              sc;
    logic [CoefW-1:0]  ma;
    logic [CoefW-1:0]  mb;
    logic [CoefW-1:0]  mc;
  } side_t;

  typedef struct packed {
    logic [QuoW-1:0] num;  // low numerator bits still to be brought down
    logic [DenW-1:0] den;
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            neg;  // quotient sign
    logic            big;  // quotient at least 2^64
  } lane_t;

endpackage

/* rtl/qrs_sqrt_cell.sv */
module qrs_sqrt_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  qrs_pkg::side_t                side_i,
  input  logic [qrs_pkg::RadW-1:0]      rad_i,
  input  logic [qrs_pkg::RootW-1:0]     root_i,
  input  logic [qrs_pkg::RemW-1:0]      rem_i,
  output logic                          valid_o,
  output qrs_pkg::side_t                side_o,
  output logic [qrs_pkg::RadW-1:0]      rad_o,
  output logic [qrs_pkg::RootW-1:0]     root_o,
  output logic [qrs_pkg::RemW-1:0]      rem_o
);

  logic [qrs_pkg::RemW+1:0] cur, trial, diff;
  logic                     take;
  logic [qrs_pkg::RootW-1:0] root_d;
  logic [qrs_pkg::RemW-1:0]  rem_d;
  logic                      valid_q;
  qrs_pkg::side_t            side_q;
  logic [qrs_pkg::RadW-1:0]  rad_q;
  logic [qrs_pkg::RootW-1:0] root_q;
  logic [qrs_pkg::RemW-1:0]  rem_q;

  // bring down the next two radicand bits, try root*4+1
  always_comb begin
    cur    = {rem_i, rad_i[2*Idx+1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    take   = (cur >= trial);
    diff   = cur - trial;
    root_d = {root_i[qrs_pkg::RootW-2:0], take};
    rem_d  = take ? diff[qrs_pkg::RemW-1:0] : cur[qrs_pkg::RemW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rad_q  <= rad_i;
      root_q <= root_d;
      rem_q  <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;

endmodule

/* rtl/qrs_div_cell.sv */
module qrs_div_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  qrs_pkg::side_t                       side_i,
  input  qrs_pkg::lane_t [qrs_pkg::Lanes-1:0]  lane_i,
  output logic                                 valid_o,
  output qrs_pkg::side_t                       side_o,
  output qrs_pkg::lane_t [qrs_pkg::Lanes-1:0]  lane_o
);

  qrs_pkg::lane_t [qrs_pkg::Lanes-1:0] lane_d;
  qrs_pkg::lane_t [qrs_pkg::Lanes-1:0] lane_q;
  logic                                valid_q;
  qrs_pkg::side_t                      side_q;

  // one restoring step per lane; remainder stays below the divisor unless big is set
  always_comb begin
    logic [qrs_pkg::DenW:0] cur, diff;
    logic                   take;
    lane_d = lane_i;
    for (int l = 0; l < int'(qrs_pkg::Lanes); l++) begin
      cur  = {lane_i[l].rem, lane_i[l].num[Idx]};
      take = (cur >= {1'b0, lane_i[l].den});
      diff = cur - {1'b0, lane_i[l].den};
      lane_d[l].rem      = take ? diff[qrs_pkg::DenW-1:0] : cur[qrs_pkg::DenW-1:0];
      lane_d[l].quo[Idx] = take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign lane_o  = lane_q;

endmodule

/* rtl/quadratic_root_solver.sv */
// Real roots of a*x^2 + b*x + c = 0, coefficients signed Q32.32.
//
// Input channel: in_valid_i with coef_a_i/coef_b_i/coef_c_i; a transaction
// completes on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with root_count_o, root_first_o, root_second_o
// and overflow_o; a transaction completes when out_valid_o is high and
// out_stall_i is low. Every input transaction yields exactly one output.
// Throughput: one transaction per cycle, sustained while out_stall_i does
// not hold a waiting result. Path from acceptance to out_valid_o: the front
// end (magnitude, products, discriminant: 5 stages), the 96-cell square
// root chain, two divider set-up stages, the 64-cell divider chain and the
// output register.
// Stall: when the output register holds an untaken result and out_stall_i
// is high, the whole pipeline freezes and in_stall_o rises in that cycle.
// Reset: all valid flags clear, epsilon returns to 42950 raw units.
// The user writes epsilon through cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
module quadratic_root_solver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [qrs_pkg::EpsW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [qrs_pkg::CoefW-1:0]   coef_a_i,
  input  logic signed [qrs_pkg::CoefW-1:0]   coef_b_i,
  input  logic signed [qrs_pkg::CoefW-1:0]   coef_c_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         root_count_o,
  output logic signed [qrs_pkg::CoefW-1:0]   root_first_o,
  output logic signed [qrs_pkg::CoefW-1:0]   root_second_o,
  output logic                               overflow_o
);

  localparam int unsigned W  = qrs_pkg::CoefW;
  localparam int unsigned PW = 2 * W;

  logic adv;
  logic [qrs_pkg::EpsW-1:0] eps_q;

  // ---------------------------------------------------------------------
  // Global advance: the pipeline moves whenever the output slot is free
  // or is being emptied this cycle.
  // ---------------------------------------------------------------------
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= qrs_pkg::EpsReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: magnitudes, signs, near-zero tests, first case decision.
  // ---------------------------------------------------------------------
  qrs_pkg::side_t side0_d;
  always_comb begin
    logic na, nb, nc;
    side0_d.sa = coef_a_i[W-1];
    side0_d.sb = coef_b_i[W-1];
    side0_d.sc = coef_c_i[W-1];
    side0_d.ma = side0_d.sa ? (W)'(-coef_a_i) : coef_a_i;
    side0_d.mb = side0_d.sb ? (W)'(-coef_b_i) : coef_b_i;
    side0_d.mc = side0_d.sc ? (W)'(-coef_c_i) : coef_c_i;
    // an exact zero is always near zero, even with epsilon at zero
    na = (side0_d.ma == '0) || (side0_d.ma < {32'b0, eps_q});
    nb = (side0_d.mb == '0) || (side0_d.mb < {32'b0, eps_q});
    nc = (side0_d.mc == '0) || (side0_d.mc < {32'b0, eps_q});
    priority if (na) begin
      side0_d.kind = nb ? qrs_pkg::K_NONE : qrs_pkg::K_LIN;
    end else if (nb) begin
      side0_d.kind = qrs_pkg::K_BTEST;
    end else if (nc) begin
      side0_d.kind = qrs_pkg::K_CZ;
    end else begin
      side0_d.kind = qrs_pkg::K_DISC;
    end
  end

  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  qrs_pkg::side_t side0_q, side1_q, side2_q, side3_q, side4_q;

  // Stage 1: 32x32 partial products of a*c, b*b and epsilon squared
  logic [W-1:0] ac00_q, ac01_q, ac10_q, ac11_q;
  logic [W-1:0] bb00_q, bb01_q, bb11_q, ee_q;
  // Stage 2: summed products, partials of eps^2 * |a|
  logic [PW-1:0] pac2_q, pbb2_q;
  logic [W-1:0]  em00_q, em01_q, em10_q, em11_q;
  // Stage 3: eps^2*|a| summed, discriminant
  logic [PW-1:0]  pac3_q, pem3_q;
  logic [PW+2:0]  dm3_q;
  logic           dneg3_q;
  // Stage 4: radicand and final case
  logic [qrs_pkg::RadW-1:0] rad4_q;

  logic [PW-1:0] pac2_d, pbb2_d, pem3_d;
  logic [PW+2:0] dm3_d, p131, q131;
  logic          dneg3_d;

  always_comb begin
    pac2_d = {64'b0, ac00_q} + ({64'b0, ac01_q} << 32) + ({64'b0, ac10_q} << 32)
           + {ac11_q, 64'b0};
    pbb2_d = {64'b0, bb00_q} + ({64'b0, bb01_q} << 33) + {bb11_q, 64'b0};
    pem3_d = {64'b0, em00_q} + ({64'b0, em01_q} << 32) + ({64'b0, em10_q} << 32)
           + {em11_q, 64'b0};
  end

  // discriminant b^2 - 4ac as sign and magnitude, magnitude zero when negative
  always_comb begin
    p131    = {3'b000, pbb2_q};
    q131    = {1'b0, pac2_q, 2'b00};
    dneg3_d = 1'b0;
    if (side2_q.sa != side2_q.sc) begin
      dm3_d = p131 + q131;
    end else if (p131 >= q131) begin
      dm3_d = p131 - q131;
    end else begin
      dm3_d   = '0;
      dneg3_d = 1'b1;
    end
  end

  qrs_pkg::side_t           side4_d;
  logic [qrs_pkg::RadW-1:0] rad4_d;
  always_comb begin
    logic lhs_lt;
    side4_d = side3_q;
    rad4_d  = '0;
    // |c|*2^64 < eps^2*|a|
    lhs_lt  = (side3_q.mc < pem3_q[PW-1:W]) ||
              ((side3_q.mc == pem3_q[PW-1:W]) && (pem3_q[W-1:0] != '0));
    unique case (side3_q.kind)
      qrs_pkg::K_BTEST: begin
        rad4_d = {pac3_q, 64'b0};
        if (lhs_lt) begin
          side4_d.kind = qrs_pkg::K_ZERO1;
        end else if ((side3_q.mc != '0) && (side3_q.sc != side3_q.sa)) begin
          side4_d.kind = qrs_pkg::K_BSQ;
        end else begin
          side4_d.kind = qrs_pkg::K_NONE;
        end
      end
      qrs_pkg::K_DISC: begin
        rad4_d = {61'b0, dm3_q};
        if (dneg3_q) begin
          side4_d.kind = qrs_pkg::K_NONE;
        end else if (dm3_q == '0) begin
          side4_d.kind = qrs_pkg::K_DZ;
        end else begin
          side4_d.kind = qrs_pkg::K_DP;
        end
      end
      default: side4_d.kind = side3_q.kind;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side0_q <= side0_d;
      side1_q <= side0_q;
      ac00_q  <= side0_q.ma[31:0]  * side0_q.mc[31:0];
      ac01_q  <= side0_q.ma[31:0]  * side0_q.mc[63:32];
      ac10_q  <= side0_q.ma[63:32] * side0_q.mc[31:0];
      ac11_q  <= side0_q.ma[63:32] * side0_q.mc[63:32];
      bb00_q  <= side0_q.mb[31:0]  * side0_q.mb[31:0];
      bb01_q  <= side0_q.mb[31:0]  * side0_q.mb[63:32];
      bb11_q  <= side0_q.mb[63:32] * side0_q.mb[63:32];
      ee_q    <= eps_q * eps_q;
      side2_q <= side1_q;
      pac2_q  <= pac2_d;
      pbb2_q  <= pbb2_d;
      em00_q  <= ee_q[31:0]  * side1_q.ma[31:0];
      em01_q  <= ee_q[31:0]  * side1_q.ma[63:32];
      em10_q  <= ee_q[63:32] * side1_q.ma[31:0];
      em11_q  <= ee_q[63:32] * side1_q.ma[63:32];
      side3_q <= side2_q;
      pac3_q  <= pac2_q;
      pem3_q  <= pem3_d;
      dm3_q   <= dm3_d;
      dneg3_q <= dneg3_d;
      side4_q <= side4_d;
      rad4_q  <= rad4_d;
    end
  end

  // ---------------------------------------------------------------------
  // Square root chain: one root bit per cell, most significant first.
  // ---------------------------------------------------------------------
  logic                      sq_v    [0:qrs_pkg::SqrtCells];
  qrs_pkg::side_t            sq_side [0:qrs_pkg::SqrtCells];
  logic [qrs_pkg::RadW-1:0]  sq_rad  [0:qrs_pkg::SqrtCells];
  logic [qrs_pkg::RootW-1:0] sq_root [0:qrs_pkg::SqrtCells];
  logic [qrs_pkg::RemW-1:0]  sq_rem  [0:qrs_pkg::SqrtCells];

  assign sq_v[0]    = v4_q;
  assign sq_side[0] = side4_q;
  assign sq_rad[0]  = rad4_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar j = 0; j < qrs_pkg::SqrtCells; j++) begin : g_sqrt
    qrs_sqrt_cell #(
      .Idx(qrs_pkg::SqrtCells - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(sq_v[j]),
      .side_i (sq_side[j]),
      .rad_i  (sq_rad[j]),
      .root_i (sq_root[j]),
      .rem_i  (sq_rem[j]),
      .valid_o(sq_v[j+1]),
      .side_o (sq_side[j+1]),
      .rad_o  (sq_rad[j+1]),
      .root_o (sq_root[j+1]),
      .rem_o  (sq_rem[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 5: numerators and divisors for the two divider lanes.
  // Lane 0 feeds the first root, lane 1 the second; plus/minus square root negates lane 0.
  // ---------------------------------------------------------------------
  logic [qrs_pkg::NumW-1:0] num5_d [qrs_pkg::Lanes];
  logic [qrs_pkg::DenW-1:0] den5_d [qrs_pkg::Lanes];
  logic                     neg5_d [qrs_pkg::Lanes];
  logic [qrs_pkg::NumW-1:0] num5_q [qrs_pkg::Lanes];
  logic [qrs_pkg::DenW-1:0] den5_q [qrs_pkg::Lanes];
  logic                     neg5_q [qrs_pkg::Lanes];
  logic                     v5_q, v6_q;
  qrs_pkg::side_t           side5_q, side6_q;

  always_comb begin
    qrs_pkg::side_t sd;
    logic [66:0] bw, sw, sum, dbs, dsb, n1, n2;
    logic        bge, n1neg, n2neg;
    sd  = sq_side[qrs_pkg::SqrtCells];
    bw  = {3'b000, sd.mb};
    sw  = {1'b0, sq_root[qrs_pkg::SqrtCells][65:0]};
    sum = bw + sw;
    dbs = bw - sw;
    dsb = sw - bw;
    bge = (bw >= sw);
    // -b + s and -b - s in sign and magnitude
    if (sd.sb) begin
      n1 = sum;                n1neg = 1'b0;
      n2 = bge ? dbs : dsb;    n2neg = !bge;
    end else begin
      n1 = bge ? dbs : dsb;    n1neg = bge;
      n2 = sum;                n2neg = 1'b1;
    end
    for (int l = 0; l < int'(qrs_pkg::Lanes); l++) begin
      num5_d[l] = '0;
      den5_d[l] = {{(qrs_pkg::DenW-1){1'b0}}, 1'b1};
      neg5_d[l] = 1'b0;
    end
    unique case (sd.kind)
      qrs_pkg::K_LIN: begin
        num5_d[0] = {3'b000, sd.mc, 32'b0};
        den5_d[0] = {1'b0, sd.mb};
        neg5_d[0] = !sd.sc ^ sd.sb;
      end
      qrs_pkg::K_BSQ: begin
        num5_d[0] = {3'b000, sq_root[qrs_pkg::SqrtCells]};
        den5_d[0] = {1'b0, sd.ma};
      end
      qrs_pkg::K_CZ: begin
        num5_d[1] = {3'b000, sd.mb, 32'b0};
        den5_d[1] = {1'b0, sd.ma};
        neg5_d[1] = !sd.sb ^ sd.sa;
      end
      qrs_pkg::K_DZ: begin
        num5_d[0] = {3'b000, sd.mb, 32'b0};
        den5_d[0] = {sd.ma, 1'b0};
        neg5_d[0] = !sd.sb ^ sd.sa;
      end
      qrs_pkg::K_DP: begin
        num5_d[0] = {n1, 32'b0};
        den5_d[0] = {sd.ma, 1'b0};
        neg5_d[0] = n1neg ^ sd.sa;
        num5_d[1] = {n2, 32'b0};
        den5_d[1] = {sd.ma, 1'b0};
        neg5_d[1] = n2neg ^ sd.sa;
      end
      default: ;
    endcase
  end

  // Stage 6: quotient range check and initial remainder
  qrs_pkg::lane_t [qrs_pkg::Lanes-1:0] lane6_d, lane6_q;
  always_comb begin
    logic [qrs_pkg::DenW-1:0] top;
    for (int l = 0; l < int'(qrs_pkg::Lanes); l++) begin
      top             = {30'b0, num5_q[l][qrs_pkg::NumW-1:qrs_pkg::QuoW]};
      lane6_d[l].num  = num5_q[l][qrs_pkg::QuoW-1:0];
      lane6_d[l].den  = den5_q[l];
      lane6_d[l].rem  = top;
      lane6_d[l].quo  = '0;
      lane6_d[l].neg  = neg5_q[l];
      lane6_d[l].big  = (top >= den5_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v5_q <= sq_v[qrs_pkg::SqrtCells];
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q <= sq_side[qrs_pkg::SqrtCells];
      num5_q  <= num5_d;
      den5_q  <= den5_d;
      neg5_q  <= neg5_d;
      side6_q <= side5_q;
      lane6_q <= lane6_d;
    end
  end

  // ---------------------------------------------------------------------
  // Divider chain: one quotient bit per cell for both lanes.
  // ---------------------------------------------------------------------
  logic                                dv_v    [0:qrs_pkg::DivCells];
  qrs_pkg::side_t                      dv_side [0:qrs_pkg::DivCells];
  qrs_pkg::lane_t [qrs_pkg::Lanes-1:0] dv_lane [0:qrs_pkg::DivCells];

  assign dv_v[0]    = v6_q;
  assign dv_side[0] = side6_q;
  assign dv_lane[0] = lane6_q;

  for (genvar j = 0; j < qrs_pkg::DivCells; j++) begin : g_div
    qrs_div_cell #(
      .Idx(qrs_pkg::DivCells - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(dv_v[j]),
      .side_i (dv_side[j]),
      .lane_i (dv_lane[j]),
      .valid_o(dv_v[j+1]),
      .side_o (dv_side[j+1]),
      .lane_o (dv_lane[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Saturation and result assembly into the output register.
  // ---------------------------------------------------------------------
  logic [W-1:0] rval [qrs_pkg::Lanes];
  logic         rovf [qrs_pkg::Lanes];
  logic [1:0]   cnt_d;
  logic [W-1:0] r1_d, r2_d;
  logic         ovf_d;

  always_comb begin
    qrs_pkg::lane_t ln;
    logic [W-1:0]   lim, mag;
    for (int l = 0; l < int'(qrs_pkg::Lanes); l++) begin
      ln      = dv_lane[qrs_pkg::DivCells][l];
      lim     = ln.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      rovf[l] = ln.big || (ln.quo > lim);
      mag     = rovf[l] ? lim : ln.quo;
      rval[l] = ln.neg ? (W)'(-mag) : mag;
    end
    cnt_d = 2'd0;
    r1_d  = '0;
    r2_d  = '0;
    ovf_d = 1'b0;
    unique case (dv_side[qrs_pkg::DivCells].kind)
      qrs_pkg::K_ZERO1: cnt_d = 2'd1;
      qrs_pkg::K_LIN, qrs_pkg::K_DZ: begin
        cnt_d = 2'd1;
        r1_d  = rval[0];
        ovf_d = rovf[0];
      end
      qrs_pkg::K_BSQ: begin
        cnt_d = 2'd2;
        r1_d  = rval[0];
        r2_d  = (W)'(-rval[0]);
        ovf_d = rovf[0];
      end
      qrs_pkg::K_CZ: begin
        cnt_d = 2'd2;
        r2_d  = rval[1];
        ovf_d = rovf[1];
      end
      qrs_pkg::K_DP: begin
        cnt_d = 2'd2;
        r1_d  = rval[0];
        r2_d  = rval[1];
        ovf_d = rovf[0] || rovf[1];
      end
      default: ;
    endcase
  end

  logic [1:0]   cnt_q;
  logic [W-1:0] r1_q, r2_q;
  logic         ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v[qrs_pkg::DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_q <= cnt_d;
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      ovf_q <= ovf_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign root_count_o  = cnt_q;
  assign root_first_o  = r1_q;
  assign root_second_o = r2_q;
  assign overflow_o    = ovf_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_count_o == 2'd0) |-> (root_first_o == '0) && (root_second_o == '0))
    else $error("roots not zero with no root reported");

  a_second_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_count_o != 2'd2) |-> (root_second_o == '0))
    else $error("second root set without two roots");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (root_count_o != 2'd3))
    else $error("root count out of range");

  a_ovf_needs_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> (root_count_o != 2'd0))
    else $error("overflow raised with no root");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

// Checks the quadratic root solver against a bit-accurate predictor held
// in this file: one result per transaction, compared field by field in order.
module testbench;

  typedef logic [191:0] wide_t;
  typedef struct {
    bit    neg;
    wide_t mag;
  } smag_t;
  typedef struct {
    logic [1:0]  count;
    logic [63:0] first;
    logic [63:0] second;
    logic        ovf;
  } roots_t;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned Drain      = 220;     // outlasts a pass through the solver pipeline

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [qrs_pkg::EpsW-1:0]   cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [qrs_pkg::CoefW-1:0]  coef_a_i = '0;
  logic [qrs_pkg::CoefW-1:0]  coef_b_i = '0;
  logic [qrs_pkg::CoefW-1:0]  coef_c_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [1:0]                 root_count_o;
  logic [qrs_pkg::CoefW-1:0]  root_first_o;
  logic [qrs_pkg::CoefW-1:0]  root_second_o;
  logic                       overflow_o;

  // predictor state: the threshold as last written
  logic [qrs_pkg::EpsW-1:0]   eps_q = qrs_pkg::EpsReset;
  roots_t            pending_roots[$];
  int unsigned       errors = 0;
  int unsigned       cycles = 0;
  bit                idle_en = 1'b1;   // random gaps on both channels

  quadratic_root_solver i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coef_a_i     (coef_a_i),
    .coef_b_i     (coef_b_i),
    .coef_c_i     (coef_c_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .root_count_o (root_count_o),
    .root_first_o (root_first_o),
    .root_second_o(root_second_o),
    .overflow_o   (overflow_o)
  );

  // clock, plus the run-away guard
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > CycleLimit) begin
          $display("timeout after %0d cycles", cycles);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic bit near_zero(logic [63:0] m);
    return (m == 0) || (m < 64'(eps_q));
  endfunction

  function automatic smag_t mk(bit neg, wide_t m);
    smag_t s;
    s.neg = neg && (m != 0);
    s.mag = m;
    return s;
  endfunction

  function automatic smag_t sm_add(smag_t x, smag_t y);
    if (x.neg == y.neg) return mk(x.neg, x.mag + y.mag);
    if (x.mag >= y.mag) return mk(x.neg, x.mag - y.mag);
    return mk(y.neg, y.mag - x.mag);
  endfunction

  // truncating division, saturated to Q32.32; overflow is sticky
  function automatic logic [63:0] trunc_div(smag_t n, smag_t d, inout bit ovf);
    wide_t       q;
    bit          neg;
    logic [63:0] lim;
    logic [63:0] m;
    q   = (d.mag == 0) ? wide_t'(0) : n.mag / d.mag;
    neg = n.neg != d.neg;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (q > wide_t'(lim)) begin
      ovf = 1'b1;
      m   = lim;
    end else begin
      m = q[63:0];
    end
    return neg ? -m : m;
  endfunction

  function automatic wide_t isqrt(wide_t n);
    wide_t r;
    wide_t t;
    r = '0;
    for (int k = 95; k >= 0; k--) begin
      t = r | (wide_t'(1) << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    roots_t      res;
    bit          sa, sb, sc, ovf;
    logic [63:0] ma, mb, mc, e2;
    wide_t       lhs, p, q, dm, s;
    smag_t       negb32, den, nb, n1, n2;
    sa = a[63]; sb = b[63]; sc = c[63];
    ma = sa ? -a : a;
    mb = sb ? -b : b;
    mc = sc ? -c : c;
    ovf = 1'b0;
    res = '{count: 2'd0, first: '0, second: '0, ovf: 1'b0};
    negb32 = mk(!sb, wide_t'(mb) << 32);
    if (near_zero(ma)) begin
      // linear, or no root at all when b vanishes too
      if (!near_zero(mb)) begin
        res.first = trunc_div(mk(!sc, wide_t'(mc) << 32), mk(sb, wide_t'(mb)), ovf);
        res.count = 2'd1;
      end
    end else if (near_zero(mb)) begin
      lhs = wide_t'(mc) << 64;
      e2  = 64'(eps_q) * 64'(eps_q);
      if (lhs < wide_t'(e2) * wide_t'(ma)) begin
        res.count = 2'd1;                  // |c/a| below eps squared: single zero root
      end else if (mc != 0 && sc != sa) begin
        res.first  = trunc_div(mk(1'b0, isqrt(lhs / wide_t'(ma))), mk(1'b0, wide_t'(1)), ovf);
        res.second = -res.first;
        res.count  = 2'd2;
      end
    end else if (near_zero(mc)) begin
      res.second = trunc_div(negb32, mk(sa, wide_t'(ma)), ovf);
      res.count  = 2'd2;
    end else begin
      p   = wide_t'(mb) * wide_t'(mb);
      q   = (wide_t'(ma) * wide_t'(mc)) << 2;
      den = mk(sa, wide_t'(ma) << 1);
      if (sa != sc || p >= q) begin
        dm = (sa != sc) ? p + q : p - q;
        if (dm == 0) begin
          res.first = trunc_div(negb32, den, ovf);
          res.count = 2'd1;
        end else begin
          s  = isqrt(dm);
          nb = mk(!sb, wide_t'(mb));
          n1 = sm_add(nb, mk(1'b0, s));
          n2 = sm_add(nb, mk(1'b1, s));
          n1.mag = n1.mag << 32;
          n2.mag = n2.mag << 32;
          res.first  = trunc_div(n1, den, ovf);
          res.second = trunc_div(n2, den, ovf);
          res.count  = 2'd2;
        end
      end
    end
    res.ovf = ovf;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------
  // valid stays high between back-to-back transactions; a gap lowers it
  task automatic send_coefs(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    coef_a_i   = a;
    coef_b_i   = b;
    coef_c_i   = c;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_roots.insert(pending_roots.size(), solve_roots(a, b, c));
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // threshold write, only with the pipeline drained
  task automatic write_epsilon(logic [qrs_pkg::EpsW-1:0] value);
    release_input();
    wait (pending_roots.size() == 0);
    repeat (Drain) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    eps_q    = value;
  endtask

  // ------------------------------------------------------------------
  // Output side
  // ------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
    errors++;
    $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, exp_v);
  endtask

  initial begin : check_roots
    roots_t      want;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_roots.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing outstanding", $realtime);
        end else begin
          want = pending_roots.pop_front();
          if (root_count_o !== want.count)
            report_mismatch("root_count", 64'(root_count_o), 64'(want.count));
          if (root_first_o !== want.first)
            report_mismatch("root_first", root_first_o, want.first);
          if (root_second_o !== want.second)
            report_mismatch("root_second", root_second_o, want.second);
          if (overflow_o !== want.ovf)
            report_mismatch("overflow", 64'(overflow_o), 64'(want.ovf));
        end
      end
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [63:0] q32(longint v);
    return 64'(v) << 32;
  endfunction

  function automatic logic [63:0] rand_coef();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = (eps_q == 0) ? 64'd0 : 64'($urandom_range(0, eps_q - 1));
      2, 3, 4: v = (64'($urandom_range(1, 1000)) << 32) | 64'($urandom);
      5:       v = 64'($urandom);
      6, 7:    v = {$urandom, $urandom};
      default: v = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
    endcase
    if (v[63] == 1'b0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  task automatic test_special_cases();
    logic [63:0] mx, mn;
    mx = 64'h7FFF_FFFF_FFFF_FFFF;
    mn = 64'h8000_0000_0000_0000;
    send_coefs('0, '0, '0);                              // nothing: no root
    send_coefs('0, q32(2), q32(-6));                     // linear
    send_coefs(64'd10, 64'd5, q32(1));                   // a and b near zero: no root
    send_coefs('0, 64'd1_000_000, mx);                   // linear, saturates
    send_coefs(q32(1), '0, q32(-4));                     // plus/minus two
    send_coefs(q32(1), '0, q32(4));                      // opposite sign missing
    send_coefs(q32(1), '0, 64'd1);                       // tiny c, same sign as a: zero root or none, by epsilon
    send_coefs(64'd100_000, '0, mn);                     // small a, large c: wide plus/minus roots
    send_coefs(q32(2), q32(4), '0);                      // c near zero
    send_coefs(64'd50_000, mx, 64'd3);                   // c near zero, saturates
    send_coefs(q32(1), q32(1), q32(1));                  // negative discriminant
    send_coefs(q32(1), q32(-2), q32(1));                 // double root
    send_coefs(q32(1), q32(-3), q32(2));                 // two roots
    send_coefs(mx, mx, mx);
    send_coefs(mn, mn, mn);
    send_coefs(mn, mx, mn);
    send_coefs(64'd50_000, mn, mx);
    send_coefs(-q32(3), q32(7), q32(5));
    send_coefs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // perfect squares k*(x - m)^2 hit the double root; the rest is mixed
  task automatic test_random_roots(int unsigned n);
    longint k, m;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        k = longint'($urandom_range(1, 200)) * ($urandom_range(0, 1) ? 1 : -1);
        m = longint'($urandom_range(0, 400)) - 200;
        send_coefs(q32(k), q32(-2 * k * m), q32(k * m * m));
      end else begin
        send_coefs(rand_coef(), rand_coef(), rand_coef());
      end
    end
  endtask

  task automatic test_threshold_settings();
    write_epsilon('0);
    test_special_cases();
    test_random_roots(150);
    write_epsilon('1);
    test_special_cases();
    test_random_roots(150);
    write_epsilon(32'd1);
    test_random_roots(120);
    write_epsilon($urandom);
    test_random_roots(120);
    write_epsilon(qrs_pkg::EpsReset);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;                      // full rate, no new gaps or stalls
    test_random_roots(200);
    release_input();
  endtask

  initial begin : run
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_special_cases();
    test_random_roots(300);
    test_threshold_settings();
    test_back_to_back();
    wait (pending_roots.size() == 0);
    repeat (Drain) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
bench/testbench.sv
